### design/zero_one_knapsack_engine_core_assert.svh
// Assertion macros shared by the knapsack engine RTL.
`ifndef ZERO_ONE_KNAPSACK_ENGINE_CORE_ASSERT_SVH
`define ZERO_ONE_KNAPSACK_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("knapsack engine: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("knapsack engine: assertion failed");

`endif

### design/kac_pkg.sv
// Package with the shared types and constants of the knapsack engine.
`default_nettype none

package kac_pkg;

    localparam int CAP_MAX_DEF = 1023;
    localparam int CAP_W       = 10;
    localparam int WEIGHT_W    = 16;
    localparam int VALUE_W     = 16;
    localparam int BEST_W      = 32;
    localparam int CMP_W       = 17;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_EMIT,
        S_CLEAR
    } kac_state_t;

    typedef struct packed {
        logic sweep_wr;
        logic clear_wr;
        logic fits;
        logic capture;
        logic out_load;
        logic clearing;
    } kac_ctrl_t;

endpackage

`default_nettype wire

### design/zero_one_knapsack_engine_core.sv
// Top level of the 0/1 knapsack dynamic-programming engine.
//
// Items arrive as requests on the s_ channel: s_tdata carries the weight and
// the value, s_tlast marks the final item of a problem. Each accepted item
// sweeps the row of best totals from the effective capacity (the capacity
// register, clamped to CAP_MAX) down to zero, one entry a cycle, and no new
// item is accepted until that sweep ends. The loop is set by the row
// memory, which is read at two addresses and written back once per cycle.
// After the final item, the drain and emit states pass before the answer, the
// best total within the capacity, is offered as a request on the m_ channel.
// The answer is held in an output register until the receiver takes it; a
// stalled receiver holds the block before its clearing pass. The clearing
// pass then writes zero to all CAP_MAX + 1 entries, one per cycle, and no
// item is accepted during it. Reset starts the same pass. The capacity register
// is written through cfg_wr_en and cfg_wr_data and must only be changed while
// the block is idle.
`default_nettype none

module zero_one_knapsack_engine_core #(
    parameter int CAP_MAX = kac_pkg::CAP_MAX_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [31:0]                  s_tdata,   // [15:0] item_weight, [31:16] item_value
    input  wire logic                         s_tlast,   // last_item
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [31:0]                  m_tdata,   // [31:0] best_value
    input  wire logic                         cfg_wr_en,
    input  wire logic [kac_pkg::CAP_W-1:0]    cfg_wr_data
);

    `include "zero_one_knapsack_engine_core_assert.svh"

    localparam int DEPTH = CAP_MAX + 1;
    localparam int AW    = $clog2(DEPTH);

    // Configuration register: the knapsack weight limit.
    logic [kac_pkg::CAP_W-1:0] capacity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= '0;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    logic [AW-1:0]                rd_a_addr;
    logic [AW-1:0]                rd_b_addr;
    logic [AW-1:0]                wr_addr;
    logic [kac_pkg::BEST_W-1:0]   cur_best;
    logic [kac_pkg::BEST_W-1:0]   src_best;
    logic [kac_pkg::BEST_W-1:0]   new_best;
    logic [kac_pkg::BEST_W-1:0]   wr_data;
    logic [kac_pkg::VALUE_W-1:0]  item_value;
    logic                         out_free;
    kac_pkg::kac_ctrl_t           ctrl;

    // The output register is free when empty or when its request completes now.
    logic                         m_tvalid_reg;
    logic [kac_pkg::BEST_W-1:0]   m_tdata_reg;
    logic [kac_pkg::BEST_W-1:0]   ans_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    kac_seq #(
        .CAP_MAX (CAP_MAX),
        .AW      (AW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_weight  (s_tdata[15:0]),
        .in_value   (s_tdata[31:16]),
        .in_last    (s_tlast),
        .capacity   (capacity_reg),
        .out_free   (out_free),
        .in_ready   (s_tready),
        .rd_a_addr  (rd_a_addr),
        .rd_b_addr  (rd_b_addr),
        .wr_addr    (wr_addr),
        .item_value (item_value),
        .ctrl       (ctrl)
    );

    kac_row_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_row_mem (
        .aclk      (aclk),
        .wr_en     (ctrl.sweep_wr || ctrl.clear_wr),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (cur_best),
        .rd_b_data (src_best)
    );

    kac_cell_upd u_cell_upd (
        .cur_best   (cur_best),
        .src_best   (src_best),
        .item_value (item_value),
        .fits       (ctrl.fits),
        .new_best   (new_best)
    );

    // The clearing pass writes zero; otherwise the updated entry is written back.
    assign wr_data = ctrl.clear_wr ? '0 : new_best;

    // The top entry of the final item's sweep is its first write, and is the answer.
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            ans_reg <= new_best;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_tdata_reg <= ans_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // No item may be taken while the row is being cleared.
    `KAC_ASSERT_NOW(a_no_accept_in_clear, aclk, aresetn, ctrl.clearing, !s_tready)
    // An answer is only loaded into a free output register.
    `KAC_ASSERT_NOW(a_load_when_free, aclk, aresetn, ctrl.out_load, out_free)
    // A sweep write-back never collides with a clearing write.
    `KAC_ASSERT_NOW(a_single_writer, aclk, aresetn, ctrl.sweep_wr, !ctrl.clear_wr)
    // A loaded answer is offered in the following cycle.
    `KAC_ASSERT_NEXT(a_load_offers, aclk, aresetn, ctrl.out_load, m_tvalid)

endmodule

`default_nettype wire

### design/kac_row_mem.sv
// Row memory: one write port and two registered read ports.
`default_nettype none

module kac_row_mem #(
    parameter int DEPTH = kac_pkg::CAP_MAX_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [kac_pkg::BEST_W-1:0]  wr_data,
    input  wire logic [AW-1:0]               rd_a_addr,
    input  wire logic [AW-1:0]               rd_b_addr,
    output logic      [kac_pkg::BEST_W-1:0]  rd_a_data,
    output logic      [kac_pkg::BEST_W-1:0]  rd_b_data
);

    logic [kac_pkg::BEST_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

`default_nettype wire

### design/kac_cell_upd.sv
// Update of one row entry: saturating add of the item value and, if the item fits, keep the larger.
`default_nettype none

module kac_cell_upd (
    input  wire logic [kac_pkg::BEST_W-1:0]  cur_best,
    input  wire logic [kac_pkg::BEST_W-1:0]  src_best,
    input  wire logic [kac_pkg::VALUE_W-1:0] item_value,
    input  wire logic                        fits,
    output logic      [kac_pkg::BEST_W-1:0]  new_best
);

    logic [kac_pkg::BEST_W:0]   sum;
    logic [kac_pkg::BEST_W-1:0] cand;

    always_comb begin
        sum  = {1'b0, src_best} + (kac_pkg::BEST_W + 1)'(item_value);
        cand = sum[kac_pkg::BEST_W] ? '1 : sum[kac_pkg::BEST_W-1:0];
        if (fits && (cand > cur_best)) begin
            new_best = cand;
        end else begin
            new_best = cur_best;
        end
    end

endmodule

`default_nettype wire

### design/kac_seq.sv
// Sequencer: row sweep addressing, write-back pipeline stage and clearing pass.
`default_nettype none

module kac_seq #(
    parameter int CAP_MAX = kac_pkg::CAP_MAX_DEF,
    parameter int AW      = $clog2(CAP_MAX + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic [kac_pkg::WEIGHT_W-1:0]  in_weight,
    input  wire logic [kac_pkg::VALUE_W-1:0]   in_value,
    input  wire logic                          in_last,
    input  wire logic [kac_pkg::CAP_W-1:0]     capacity,
    input  wire logic                          out_free,
    output logic                               in_ready,
    output logic      [AW-1:0]                 rd_a_addr,
    output logic      [AW-1:0]                 rd_b_addr,
    output logic      [AW-1:0]                 wr_addr,
    output logic      [kac_pkg::VALUE_W-1:0]   item_value,
    output kac_pkg::kac_ctrl_t                 ctrl
);

    kac_pkg::kac_state_t state_reg, state_next;

    logic [kac_pkg::WEIGHT_W-1:0] weight_reg;
    logic [kac_pkg::VALUE_W-1:0]  value_reg;
    logic                         last_reg;
    logic [AW-1:0]                top_reg;
    logic [AW-1:0]                w_reg;
    logic [AW-1:0]                clr_reg;
    logic                         pend_valid_reg;
    logic [AW-1:0]                pend_addr_reg;
    logic                         pend_fit_reg;
    logic                         pend_first_reg;

    logic [kac_pkg::CMP_W-1:0] cap_ext;
    logic [AW-1:0]             top_eff;
    logic                      accept;
    logic                      fits_now;

    always_comb begin
        cap_ext  = kac_pkg::CMP_W'(capacity);
        top_eff  = (cap_ext > kac_pkg::CMP_W'(CAP_MAX)) ? AW'(CAP_MAX) : AW'(cap_ext);
        accept   = in_valid && in_ready;
        fits_now = kac_pkg::WEIGHT_W'(w_reg) >= weight_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kac_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = kac_pkg::S_SWEEP;
                end
            end
            kac_pkg::S_SWEEP: begin
                if (w_reg == '0) begin
                    state_next = last_reg ? kac_pkg::S_DRAIN : kac_pkg::S_IDLE;
                end
            end
            kac_pkg::S_DRAIN: begin
                state_next = kac_pkg::S_EMIT;
            end
            kac_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = kac_pkg::S_CLEAR;
                end
            end
            kac_pkg::S_CLEAR: begin
                if (clr_reg == AW'(CAP_MAX)) begin
                    state_next = kac_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = kac_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        ctrl.out_load = 1'b0;
        ctrl.clear_wr = 1'b0;
        ctrl.clearing = 1'b0;
        wr_addr       = pend_addr_reg;
        unique case (state_reg)
            kac_pkg::S_IDLE: begin
                in_ready = 1'b1;
            end
            kac_pkg::S_EMIT: begin
                ctrl.out_load = out_free;
            end
            kac_pkg::S_CLEAR: begin
                ctrl.clear_wr = 1'b1;
                ctrl.clearing = 1'b1;
                wr_addr       = clr_reg;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
        ctrl.sweep_wr = pend_valid_reg;
        ctrl.fits     = pend_fit_reg;
        ctrl.capture  = pend_valid_reg && pend_first_reg && last_reg;
        rd_a_addr     = w_reg;
        rd_b_addr     = w_reg - AW'(weight_reg);
        item_value    = value_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= kac_pkg::S_CLEAR;
            clr_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= (state_reg == kac_pkg::S_SWEEP);
            if (state_reg == kac_pkg::S_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end else begin
                clr_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            weight_reg <= in_weight;
            value_reg  <= in_value;
            last_reg   <= in_last;
            top_reg    <= top_eff;
            w_reg      <= top_eff;
        end else if (state_reg == kac_pkg::S_SWEEP) begin
            w_reg <= w_reg - AW'(1);
        end
        pend_addr_reg  <= w_reg;
        pend_fit_reg   <= fits_now;
        pend_first_reg <= (w_reg == top_reg);
    end

endmodule

`default_nettype wire
